[hw/rtl/aesd_pkg.sv]
// Package for the AES block decrypter: word types, S-box tables and GF(2^8) helpers.
// Has no dependencies; every other file in the block imports it.

package aesd_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int RCON_COUNT = 10;

   typedef struct packed {
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [63:0] key_0;
      logic [63:0] key_1;
      logic [63:0] key_2;
      logic [63:0] key_3;
   } req_type;

   typedef struct packed {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
   } rsp_type;

   localparam logic [7:0] RCON_TBL [RCON_COUNT] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX_TBL [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam logic [7:0] INV_SBOX_TBL [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
   endfunction

   function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
      return {SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]], SBOX_TBL[w[31:24]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      for (int i = 0; i < 4; i++) begin
         a[i]   = w[31 - 8 * i -: 8];
         x2[i]  = xtime(a[i]);
         x4[i]  = xtime(x2[i]);
         x8[i]  = xtime(x4[i]);
         m9[i]  = x8[i] ^ a[i];
         m11[i] = x8[i] ^ x2[i] ^ a[i];
         m13[i] = x8[i] ^ x4[i] ^ a[i];
         m14[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   // Byte k of the state sits at bits 127-8k down; row k mod 4, column k div 4.
   function automatic logic [BLOCK_BITS-1:0] inv_shift_sub(input logic [BLOCK_BITS-1:0] s);
      logic [BLOCK_BITS-1:0] t;
      int src;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            src = r + 4 * ((c - r + 4) % 4);
            t[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX_TBL[s[127 - 8 * src -: 8]];
         end
      end
      return t;
   endfunction

endpackage

[hw/rtl/aesd_kexp.sv]
// One forward key-expansion stage: extends the key window by up to four words.
// Depends on aesd_pkg for the S-box and round constants.

module aesd_kexp #(
   parameter int KEY_WORDS = 4,
   parameter int BASE      = 0,
   parameter int STEP      = 4
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [127:0]                blk_i,
   input  logic [KEY_WORDS-1:0][31:0]  win_i,
   output logic [127:0]                blk_o,
   output logic [KEY_WORDS-1:0][31:0]  win_o
);
   import aesd_pkg::*;

   logic [31:0]                ext [KEY_WORDS+STEP];
   logic [KEY_WORDS-1:0][31:0] win_in;
   logic [KEY_WORDS-1:0][31:0] win_ff;
   logic [127:0]               blk_ff;

   for (genvar k = 0; k < KEY_WORDS; k++) begin : g_old
      assign ext[k] = win_i[k];
   end

   for (genvar m = 0; m < STEP; m++) begin : g_new
      localparam int IDX = BASE + KEY_WORDS + m;
      if (IDX % KEY_WORDS == 0) begin : g_rot
         localparam int RI = IDX / KEY_WORDS - 1;
         assign ext[KEY_WORDS+m] = ext[m] ^ rot_sub_word(ext[KEY_WORDS+m-1])
                                   ^ {RCON_TBL[RI], 24'h0};
      end else if (KEY_WORDS > 6 && IDX % KEY_WORDS == 4) begin : g_sub
         assign ext[KEY_WORDS+m] = ext[m] ^ sub_word(ext[KEY_WORDS+m-1]);
      end else begin : g_xor
         assign ext[KEY_WORDS+m] = ext[m] ^ ext[KEY_WORDS+m-1];
      end
   end

   for (genvar k = 0; k < KEY_WORDS; k++) begin : g_win
      assign win_in[k] = ext[STEP+k];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_ff <= win_in;
         blk_ff <= blk_i;
      end
   end

   assign blk_o = blk_ff;
   assign win_o = win_ff;

endmodule

[hw/rtl/aesd_round.sv]
// One inverse-cipher round stage with its backward key-schedule step.
// Depends on aesd_pkg for the inverse S-box, S-box and column mixing.

module aesd_round #(
   parameter int KEY_WORDS = 4,
   parameter int ROUND     = 0,
   parameter int BASE      = 4,
   parameter bit FIRST     = 1'b0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [127:0]                st_i,
   input  logic [KEY_WORDS-1:0][31:0]  win_i,
   output logic [127:0]                st_o,
   output logic [KEY_WORDS-1:0][31:0]  win_o
);
   import aesd_pkg::*;

   localparam int RK_OFS = 4 * ROUND - (BASE - 4);

   logic [31:0]                ext [KEY_WORDS+4];
   logic [127:0]               st_pre;
   logic [127:0]               st_ark;
   logic [127:0]               rk;
   logic [127:0]               st_in;
   logic [127:0]               st_ff;
   logic [KEY_WORDS-1:0][31:0] win_in;
   logic [KEY_WORDS-1:0][31:0] win_ff;

   for (genvar k = 0; k < KEY_WORDS; k++) begin : g_old
      assign ext[4+k] = win_i[k];
   end

   // Earlier schedule words follow from w[j] = w[j+Nk] ^ f(w[j+Nk-1]).
   for (genvar m = 0; m < 4; m++) begin : g_back
      localparam int J   = BASE - 4 + m;
      localparam int IDX = J + KEY_WORDS;
      if (J < 0) begin : g_none
         assign ext[m] = '0;
      end else if (IDX % KEY_WORDS == 0) begin : g_rot
         localparam int RI = IDX / KEY_WORDS - 1;
         assign ext[m] = ext[m+KEY_WORDS] ^ rot_sub_word(ext[m+KEY_WORDS-1])
                         ^ {RCON_TBL[RI], 24'h0};
      end else if (KEY_WORDS > 6 && IDX % KEY_WORDS == 4) begin : g_sub
         assign ext[m] = ext[m+KEY_WORDS] ^ sub_word(ext[m+KEY_WORDS-1]);
      end else begin : g_xor
         assign ext[m] = ext[m+KEY_WORDS] ^ ext[m+KEY_WORDS-1];
      end
   end

   for (genvar k = 0; k < KEY_WORDS; k++) begin : g_win
      assign win_in[k] = ext[k];
   end

   assign rk = {ext[RK_OFS], ext[RK_OFS+1], ext[RK_OFS+2], ext[RK_OFS+3]};

   if (FIRST) begin : g_first
      assign st_pre = st_i ^ {win_i[KEY_WORDS-4], win_i[KEY_WORDS-3],
                              win_i[KEY_WORDS-2], win_i[KEY_WORDS-1]};
   end else begin : g_mid
      assign st_pre = st_i;
   end

   assign st_ark = inv_shift_sub(st_pre) ^ rk;

   if (ROUND > 0) begin : g_mix
      for (genvar c = 0; c < 4; c++) begin : g_col
         assign st_in[127-32*c -: 32] = inv_mix_col(st_ark[127-32*c -: 32]);
      end
   end else begin : g_last
      assign st_in = st_ark;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff  <= st_in;
         win_ff <= win_in;
      end
   end

   assign st_o  = st_ff;
   assign win_o = win_ff;

endmodule

[hw/rtl/aes_block_decrypt.sv]
// Top level of the pipelined AES block decrypter (ECB, key expanded per word).
// Depends on aesd_pkg, aesd_kexp and aesd_round.
//
// The request channel takes one word per cycle unless stalled: a ciphertext
// block and a key of KEY_WORDS 32-bit words (4, 6 or 8 for 128, 192 or 256-bit
// keys). The response channel returns the plaintext block in the order the
// requests were taken. The key schedule is run forwards to its last words in
// the first stages, then run backwards one round key per stage alongside the
// inverse rounds, so no key is kept between words. Throughput is one word per
// cycle while rsp_ready is high, set by one register stage per key step or
// round. Reset empties every stage. When the receiver stalls, words in flight
// close up behind the output register, and requests are still taken until
// every stage holds a word.

module aes_block_decrypt #(
   parameter int KEY_WORDS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aesd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aesd_pkg::rsp_type rsp_data
);
   import aesd_pkg::*;

   localparam int NR     = KEY_WORDS + 6;
   localparam int SCHED  = 4 * (NR + 1);
   localparam int FWD    = (SCHED - KEY_WORDS + 3) / 4;
   localparam int STAGES = FWD + NR;

   logic [STAGES-1:0]          v_ff;
   logic [STAGES-1:0]          v_in;
   logic [STAGES:0]            take;
   logic [127:0]               st_w  [STAGES+1];
   logic [KEY_WORDS-1:0][31:0] win_w [STAGES+1];
   logic [255:0]               key_all;

   assign key_all  = {req_data.key_0, req_data.key_1, req_data.key_2, req_data.key_3};
   assign st_w[0]  = {req_data.block_hi, req_data.block_lo};
   for (genvar k = 0; k < KEY_WORDS; k++) begin : g_key
      assign win_w[0][k] = key_all[255 - 32 * k -: 32];
   end

   assign take[STAGES] = rsp_ready;
   for (genvar s = 0; s < STAGES; s++) begin : g_ctl
      assign take[s] = !v_ff[s] || take[s+1];
      if (s == 0) begin : g_head
         assign v_in[s] = take[s] ? req_valid : v_ff[s];
      end else begin : g_body
         assign v_in[s] = take[s] ? v_ff[s-1] : v_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s < FWD) begin : g_fwd
         localparam int LEFT = SCHED - KEY_WORDS - 4 * s;
         aesd_kexp #(
            .KEY_WORDS (KEY_WORDS),
            .BASE      (4 * s),
            .STEP      (LEFT < 4 ? LEFT : 4)
         ) u_kexp (
            .clock (clock),
            .en    (take[s]),
            .blk_i (st_w[s]),
            .win_i (win_w[s]),
            .blk_o (st_w[s+1]),
            .win_o (win_w[s+1])
         );
      end else begin : g_rnd
         aesd_round #(
            .KEY_WORDS (KEY_WORDS),
            .ROUND     (NR - 1 - (s - FWD)),
            .BASE      (SCHED - KEY_WORDS - 4 * (s - FWD)),
            .FIRST     (s == FWD)
         ) u_round (
            .clock (clock),
            .en    (take[s]),
            .st_i  (st_w[s]),
            .win_i (win_w[s]),
            .st_o  (st_w[s+1]),
            .win_o (win_w[s+1])
         );
      end
   end

   assign req_ready         = take[0];
   assign rsp_valid         = v_ff[STAGES-1];
   assign rsp_data.plain_hi = st_w[STAGES][127:64];
   assign rsp_data.plain_lo = st_w[STAGES][63:0];

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken while every stage is full and the output is stalled");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(v_ff) == $past($countones(v_ff))
         + ($past(req_valid && req_ready) ? 1 : 0)
         - ($past(rsp_valid && rsp_ready) ? 1 : 0))
      else $error("words in flight do not match those taken and delivered");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
